/* sv/gfp2_pkg.sv */
// Shared types, constants and field arithmetic for the GF(p^2) butterfly.
// Arithmetic is modulo the Mersenne prime p = 2^61 - 1; no dependencies.
package gfp2_pkg;

    localparam int FW = 61;
    localparam int MUL_LAT = 3;

    typedef logic [FW-1:0] fe_t;

    localparam fe_t P_MOD          = '1;
    localparam fe_t CUBE_ROOT_RST  = '0;
    localparam fe_t HALF_INV_RST   = 61'd1152921504606846976;
    localparam fe_t THIRD_INV_RST  = 61'd1537228672809129301;

    localparam logic [1:0] REQ_FWD2 = 2'd0;
    localparam logic [1:0] REQ_INV2 = 2'd1;
    localparam logic [1:0] REQ_FWD3 = 2'd2;
    localparam logic [1:0] REQ_INV3 = 2'd3;

    localparam logic [1:0] CFG_CUBE_ROOT = 2'd0;
    localparam logic [1:0] CFG_HALF_INV  = 2'd1;
    localparam logic [1:0] CFG_THIRD_INV = 2'd2;

    typedef struct packed {
        fe_t re;
        fe_t im;
    } gfe_t;

    typedef struct packed {
        logic [1:0] req_type;
        fe_t        a_re;
        fe_t        a_im;
        fe_t        b_re;
        fe_t        b_im;
        fe_t        c_re;
        fe_t        c_im;
        fe_t        tw_re;
        fe_t        tw_im;
    } in_t;

    typedef struct packed {
        fe_t out0_re;
        fe_t out0_im;
        fe_t out1_re;
        fe_t out1_im;
        fe_t out2_re;
        fe_t out2_im;
    } out_t;

    // Side data that rides beside the first multiplier layer.
    typedef struct packed {
        logic [1:0] mode;
        gfe_t       a;
        gfe_t       c;
        gfe_t       w;
        gfe_t       apb;
        gfe_t       amb;
        gfe_t       amc;
    } ctx1_t;

    // Side data beside the second multiplier layer.
    typedef struct packed {
        logic [1:0] mode;
        gfe_t       r0;
        gfe_t       r1;
        gfe_t       a;
        gfe_t       u1;
        gfe_t       apu1;
        gfe_t       amu1;
        gfe_t       w;
        gfe_t       w2;
    } ctx2_t;

    // Side data beside the third multiplier layer.
    typedef struct packed {
        logic [1:0] mode;
        gfe_t       r0;
        gfe_t       r1;
        gfe_t       amu1;
        gfe_t       amu2;
    } ctx3_t;

    // The all-ones word is the second encoding of zero.
    function automatic fe_t f_canon(fe_t x);
        return (x == P_MOD) ? '0 : x;
    endfunction

    function automatic fe_t f_add(fe_t x, fe_t y);
        logic [FW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, P_MOD}) ? fe_t'(s - {1'b0, P_MOD}) : s[FW-1:0];
    endfunction

    function automatic fe_t f_sub(fe_t x, fe_t y);
        logic [FW:0] s;
        s = {1'b0, x} + {1'b0, P_MOD} - {1'b0, y};
        return (x >= y) ? fe_t'(x - y) : s[FW-1:0];
    endfunction

    function automatic gfe_t g_add(gfe_t x, gfe_t y);
        gfe_t r;
        r.re = f_add(x.re, y.re);
        r.im = f_add(x.im, y.im);
        return r;
    endfunction

    function automatic gfe_t g_sub(gfe_t x, gfe_t y);
        gfe_t r;
        r.re = f_sub(x.re, y.re);
        r.im = f_sub(x.im, y.im);
        return r;
    endfunction

    function automatic gfe_t g_canon(fe_t re, fe_t im);
        gfe_t r;
        r.re = f_canon(re);
        r.im = f_canon(im);
        return r;
    endfunction

    // A base field scalar as an element with zero imaginary part.
    function automatic gfe_t g_scalar(fe_t k);
        gfe_t r;
        r.re = k;
        r.im = '0;
        return r;
    endfunction

endpackage

/* sv/gfp2_delay.sv */
// Enabled shift line that carries side data beside a multiplier.
// Depends on gfp2_pkg for the default depth.
module gfp2_delay
    import gfp2_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = MUL_LAT
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] sr_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[DEPTH-1];

endmodule

/* sv/gfp2_cmul.sv */
// Three-stage GF(p^2) multiplier: partial products, fold, final reduce and combine.
// Depends on gfp2_pkg for the element type and field add and subtract.
module gfp2_cmul
    import gfp2_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  gfe_t x,
    input  gfe_t y,
    output gfe_t z
);

    // Products: re*re, im*im, im*re, re*im.
    fe_t         opa [4];
    fe_t         opb [4];
    logic [63:0] pp_reg [4][4];
    logic [61:0] fold_reg [4];
    logic [121:0] prod [4];
    fe_t         fin [4];
    gfe_t        z_reg;
    gfe_t        z_next;

    always_comb begin
        opa[0] = x.re; opb[0] = y.re;
        opa[1] = x.im; opb[1] = y.im;
        opa[2] = x.im; opb[2] = y.re;
        opa[3] = x.re; opb[3] = y.im;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                pp_reg[k][0] <= opa[k][31:0]  * opb[k][31:0];
                pp_reg[k][1] <= opa[k][31:0]  * opb[k][60:32];
                pp_reg[k][2] <= opa[k][60:32] * opb[k][31:0];
                pp_reg[k][3] <= opa[k][60:32] * opb[k][60:32];
            end
        end
    end

    // 2^61 = 1 mod p, so the high half of the product folds onto the low half.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = {58'd0, pp_reg[k][0]}
                    + {26'd0, pp_reg[k][1], 32'd0}
                    + {26'd0, pp_reg[k][2], 32'd0}
                    + {pp_reg[k][3][57:0], 64'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                fold_reg[k] <= {1'b0, prod[k][60:0]} + {1'b0, prod[k][121:61]};
            end
        end
    end

    always_comb begin
        logic [61:0] t;
        t = '0;
        for (int k = 0; k < 4; k++) begin
            t = {1'b0, fold_reg[k][60:0]} + {61'd0, fold_reg[k][61]};
            fin[k] = (t >= {1'b0, P_MOD}) ? fe_t'(t - {1'b0, P_MOD}) : t[60:0];
        end
        z_next.re = f_sub(fin[0], fin[1]);
        z_next.im = f_add(fin[2], fin[3]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= z_next;
        end
    end

    assign z = z_reg;

endmodule

/* sv/gf_p2_ntt_butterfly.sv */
// Radix-2 / radix-3 butterfly over GF(p^2), p = 2^61 - 1, as a 14-register pipeline.
// Accepts one request per cycle while the output register is not stalled.
// The depth is set by three layers of three-stage multipliers with an add stage around each.
// The whole pipeline stalls together while the output register holds an untaken result.
// Reset (aresetn low, synchronous) clears all valid bits and restores the constant registers.
// Depends on gfp2_pkg, gfp2_cmul and gfp2_delay.
module gf_p2_ntt_butterfly
    import gfp2_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  fe_t        cfg_wdata
);

    localparam int NSTG = 2 + 3 * (MUL_LAT + 1);

    logic            en;
    logic [NSTG-1:0] vld_reg;

    fe_t cube_root_reg, half_inv_reg, third_inv_reg;

    // Stage 0: canonical inputs and first sums.
    logic [1:0] s0_mode_reg;
    gfe_t s0_a_reg, s0_b_reg, s0_c_reg, s0_w_reg;
    gfe_t s0_apb_reg, s0_amb_reg, s0_amc_reg, s0_bmc_reg;
    gfe_t a_in, b_in, c_in, w_in;

    // Stage 1: first multiplier layer operands.
    gfe_t  p1x_reg, p1y_reg, q1x_reg, q1y_reg, r1x_reg, r1y_reg;
    gfe_t  p1x_next, p1y_next, q1x_next, q1y_next, r1x_next, r1y_next;
    ctx1_t ctx1_reg, ctx1_next, ctx1_d;
    gfe_t  p1_z, q1_z, r1_z;

    // Stage 5: second layer operands.
    gfe_t  p2x_reg, p2y_reg, q2x_reg, q2y_reg;
    gfe_t  p2x_next, p2y_next, q2x_next, q2y_next;
    ctx2_t ctx2_reg, ctx2_next, ctx2_d;
    gfe_t  p2_z, q2_z;

    // Stage 9: third layer operands.
    gfe_t  p3x_reg, p3y_reg, q3x_reg, q3y_reg;
    gfe_t  p3x_next, p3y_next, q3x_next, q3y_next;
    ctx3_t ctx3_reg, ctx3_next, ctx3_d;
    gfe_t  p3_z, q3_z;
    gfe_t  u2, e;

    out_t out_reg, out_next;
    gfe_t r1_fin, r2_fin;

    assign en      = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NSTG-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            cube_root_reg <= CUBE_ROOT_RST;
            half_inv_reg  <= HALF_INV_RST;
            third_inv_reg <= THIRD_INV_RST;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[NSTG-2:0], s_valid};
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CUBE_ROOT: cube_root_reg <= f_canon(cfg_wdata);
                    CFG_HALF_INV:  half_inv_reg  <= f_canon(cfg_wdata);
                    CFG_THIRD_INV: third_inv_reg <= f_canon(cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // ---------------- stage 0 ----------------
    always_comb begin
        a_in = g_canon(s_data.a_re, s_data.a_im);
        b_in = g_canon(s_data.b_re, s_data.b_im);
        c_in = g_canon(s_data.c_re, s_data.c_im);
        w_in = g_canon(s_data.tw_re, s_data.tw_im);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_mode_reg <= s_data.req_type;
            s0_a_reg    <= a_in;
            s0_b_reg    <= b_in;
            s0_c_reg    <= c_in;
            s0_w_reg    <= w_in;
            s0_apb_reg  <= g_add(a_in, b_in);
            s0_amb_reg  <= g_sub(a_in, b_in);
            s0_amc_reg  <= g_sub(a_in, c_in);
            s0_bmc_reg  <= g_sub(b_in, c_in);
        end
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        p1x_next = '0; p1y_next = '0;
        q1x_next = '0; q1y_next = '0;
        r1x_next = '0; r1y_next = '0;
        case (s0_mode_reg)
            REQ_FWD2: begin
                p1x_next = s0_amb_reg; p1y_next = s0_w_reg;
            end
            REQ_INV2: begin
                p1x_next = s0_b_reg;   p1y_next = s0_w_reg;
            end
            REQ_FWD3: begin
                p1x_next = s0_w_reg;   p1y_next = s0_w_reg;
                q1x_next = s0_b_reg;   q1y_next = s0_w_reg;
            end
            REQ_INV3: begin
                p1x_next = s0_w_reg;   p1y_next = s0_w_reg;
                q1x_next = s0_bmc_reg; q1y_next = g_scalar(cube_root_reg);
                r1x_next = g_add(s0_apb_reg, s0_c_reg);
                r1y_next = g_scalar(third_inv_reg);
            end
            default: ;
        endcase
        ctx1_next.mode = s0_mode_reg;
        ctx1_next.a    = s0_a_reg;
        ctx1_next.c    = s0_c_reg;
        ctx1_next.w    = s0_w_reg;
        ctx1_next.apb  = s0_apb_reg;
        ctx1_next.amb  = s0_amb_reg;
        ctx1_next.amc  = s0_amc_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1x_reg  <= p1x_next; p1y_reg <= p1y_next;
            q1x_reg  <= q1x_next; q1y_reg <= q1y_next;
            r1x_reg  <= r1x_next; r1y_reg <= r1y_next;
            ctx1_reg <= ctx1_next;
        end
    end

    gfp2_cmul u_mul_p1 (.aclk(aclk), .en(en), .x(p1x_reg), .y(p1y_reg), .z(p1_z));
    gfp2_cmul u_mul_q1 (.aclk(aclk), .en(en), .x(q1x_reg), .y(q1y_reg), .z(q1_z));
    gfp2_cmul u_mul_r1 (.aclk(aclk), .en(en), .x(r1x_reg), .y(r1y_reg), .z(r1_z));

    gfp2_delay #(.WIDTH($bits(ctx1_t)), .DEPTH(MUL_LAT)) u_dly1 (
        .aclk(aclk), .en(en), .d(ctx1_reg), .q(ctx1_d)
    );

    // ---------------- stage 5 ----------------
    always_comb begin
        p2x_next = '0; p2y_next = '0;
        q2x_next = '0; q2y_next = '0;
        ctx2_next      = '0;
        ctx2_next.mode = ctx1_d.mode;
        ctx2_next.a    = ctx1_d.a;
        case (ctx1_d.mode)
            REQ_FWD2: begin
                ctx2_next.r0 = ctx1_d.apb;
                ctx2_next.r1 = p1_z;
            end
            REQ_INV2: begin
                p2x_next = g_add(ctx1_d.a, p1_z); p2y_next = g_scalar(half_inv_reg);
                q2x_next = g_sub(ctx1_d.a, p1_z); q2y_next = g_scalar(half_inv_reg);
            end
            REQ_FWD3: begin
                // p1 holds w^2 and q1 holds b*w here.
                p2x_next = ctx1_d.c; p2y_next = p1_z;
                ctx2_next.u1   = q1_z;
                ctx2_next.apu1 = g_add(ctx1_d.a, q1_z);
                ctx2_next.amu1 = g_sub(ctx1_d.a, q1_z);
            end
            REQ_INV3: begin
                p2x_next = g_sub(ctx1_d.amb, q1_z); p2y_next = g_scalar(third_inv_reg);
                q2x_next = g_add(ctx1_d.amc, q1_z); q2y_next = g_scalar(third_inv_reg);
                ctx2_next.r0 = r1_z;
                ctx2_next.w  = ctx1_d.w;
                ctx2_next.w2 = p1_z;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2x_reg  <= p2x_next; p2y_reg <= p2y_next;
            q2x_reg  <= q2x_next; q2y_reg <= q2y_next;
            ctx2_reg <= ctx2_next;
        end
    end

    gfp2_cmul u_mul_p2 (.aclk(aclk), .en(en), .x(p2x_reg), .y(p2y_reg), .z(p2_z));
    gfp2_cmul u_mul_q2 (.aclk(aclk), .en(en), .x(q2x_reg), .y(q2y_reg), .z(q2_z));

    gfp2_delay #(.WIDTH($bits(ctx2_t)), .DEPTH(MUL_LAT)) u_dly2 (
        .aclk(aclk), .en(en), .d(ctx2_reg), .q(ctx2_d)
    );

    // ---------------- stage 9 ----------------
    always_comb begin
        p3x_next = '0; p3y_next = '0;
        q3x_next = '0; q3y_next = '0;
        u2 = p2_z;
        e  = g_sub(ctx2_d.u1, p2_z);
        ctx3_next.mode = ctx2_d.mode;
        ctx3_next.r0   = ctx2_d.r0;
        ctx3_next.r1   = ctx2_d.r1;
        ctx3_next.amu1 = ctx2_d.amu1;
        ctx3_next.amu2 = '0;
        case (ctx2_d.mode)
            REQ_FWD2: ;
            REQ_INV2: begin
                ctx3_next.r0 = p2_z;
                ctx3_next.r1 = q2_z;
            end
            REQ_FWD3: begin
                ctx3_next.r0   = g_add(ctx2_d.apu1, u2);
                ctx3_next.amu2 = g_sub(ctx2_d.a, u2);
                p3x_next = e; p3y_next = g_scalar(cube_root_reg);
            end
            REQ_INV3: begin
                p3x_next = p2_z; p3y_next = ctx2_d.w;
                q3x_next = q2_z; q3y_next = ctx2_d.w2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3x_reg  <= p3x_next; p3y_reg <= p3y_next;
            q3x_reg  <= q3x_next; q3y_reg <= q3y_next;
            ctx3_reg <= ctx3_next;
        end
    end

    gfp2_cmul u_mul_p3 (.aclk(aclk), .en(en), .x(p3x_reg), .y(p3y_reg), .z(p3_z));
    gfp2_cmul u_mul_q3 (.aclk(aclk), .en(en), .x(q3x_reg), .y(q3y_reg), .z(q3_z));

    gfp2_delay #(.WIDTH($bits(ctx3_t)), .DEPTH(MUL_LAT)) u_dly3 (
        .aclk(aclk), .en(en), .d(ctx3_reg), .q(ctx3_d)
    );

    // ---------------- stage 13: output register ----------------
    always_comb begin
        r1_fin = ctx3_d.r1;
        r2_fin = '0;
        case (ctx3_d.mode)
            REQ_FWD2, REQ_INV2: ;
            REQ_FWD3: begin
                r1_fin = g_add(ctx3_d.amu2, p3_z);
                r2_fin = g_sub(ctx3_d.amu1, p3_z);
            end
            REQ_INV3: begin
                r1_fin = p3_z;
                r2_fin = q3_z;
            end
            default: ;
        endcase
        out_next.out0_re = ctx3_d.r0.re;
        out_next.out0_im = ctx3_d.r0.im;
        out_next.out1_re = r1_fin.re;
        out_next.out1_im = r1_fin.im;
        out_next.out2_re = r2_fin.re;
        out_next.out2_im = r2_fin.im;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    // An accepted request always occupies the first stage next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    // While stalled no request may move or vanish.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits changed during a stall");

    // The last internal stage reaches the output whenever the pipeline advances.
    a_reach_output: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NSTG-2] && en |=> m_valid)
        else $error("request lost before the output register");

    // Results are always fully reduced.
    a_out_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out0_re != P_MOD) && (m_data.out0_im != P_MOD)
                 && (m_data.out1_re != P_MOD) && (m_data.out1_im != P_MOD)
                 && (m_data.out2_re != P_MOD) && (m_data.out2_im != P_MOD))
        else $error("result not fully reduced");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the GF(p^2) radix-2/radix-3 butterfly, p = 2^61 - 1.
// It holds its own modular-arithmetic predictor and drives random traffic under back-pressure.
// Depends on gfp2_pkg and the gf_p2_ntt_butterfly RTL.
`timescale 1ns / 100ps

module testbench;
    import gfp2_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 30;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_CUBE_ROOT;
    fe_t        cfg_wdata = '0;

    gf_p2_ntt_butterfly u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copies of the constant registers.
    fe_t cube_root_q  = CUBE_ROOT_RST;
    fe_t half_inv_q   = HALF_INV_RST;
    fe_t third_inv_q  = THIRD_INV_RST;

    in_t  pending_requests[$];
    out_t expected_butterflies[$];
    int   error_count = 0;
    bit   idle_gaps = 1'b0;
    bit   long_hold_req = 1'b0;
    bit   long_hold_done = 1'b0;

    function automatic fe_t mod_reduce(fe_t x);
        return (x == P_MOD) ? '0 : x;
    endfunction

    function automatic fe_t mod_add(fe_t x, fe_t y);
        logic [61:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, P_MOD}) s = s - {1'b0, P_MOD};
        return s[60:0];
    endfunction

    function automatic fe_t mod_sub(fe_t x, fe_t y);
        logic [61:0] s;
        s = {1'b0, x} + {1'b0, P_MOD} - {1'b0, y};
        if (s >= {1'b0, P_MOD}) s = s - {1'b0, P_MOD};
        return s[60:0];
    endfunction

    // Since 2^61 = 1 mod p, the high half of the product folds onto the low half.
    function automatic fe_t mod_mul(fe_t x, fe_t y);
        logic [121:0] prod;
        logic [61:0]  s;
        prod = {61'b0, x} * {61'b0, y};
        s = {1'b0, prod[60:0]} + {1'b0, prod[121:61]};
        s = {1'b0, s[60:0]} + {61'd0, s[61]};
        if (s >= {1'b0, P_MOD}) s = s - {1'b0, P_MOD};
        return s[60:0];
    endfunction

    function automatic fe_t mod_pow(fe_t base_v, logic [60:0] e);
        fe_t acc;
        acc = 61'd1;
        for (int k = 60; k >= 0; k--) begin
            acc = mod_mul(acc, acc);
            if (e[k]) acc = mod_mul(acc, base_v);
        end
        return acc;
    endfunction

    function automatic gfe_t ext_add(gfe_t x, gfe_t y);
        gfe_t r;
        r.re = mod_add(x.re, y.re);
        r.im = mod_add(x.im, y.im);
        return r;
    endfunction

    function automatic gfe_t ext_sub(gfe_t x, gfe_t y);
        gfe_t r;
        r.re = mod_sub(x.re, y.re);
        r.im = mod_sub(x.im, y.im);
        return r;
    endfunction

    function automatic gfe_t ext_scale(gfe_t x, fe_t k);
        gfe_t r;
        r.re = mod_mul(x.re, k);
        r.im = mod_mul(x.im, k);
        return r;
    endfunction

    function automatic gfe_t ext_mul(gfe_t x, gfe_t y);
        gfe_t r;
        r.re = mod_sub(mod_mul(x.re, y.re), mod_mul(x.im, y.im));
        r.im = mod_add(mod_mul(x.im, y.re), mod_mul(x.re, y.im));
        return r;
    endfunction

    function automatic gfe_t ext_load(fe_t re, fe_t im);
        gfe_t r;
        r.re = mod_reduce(re);
        r.im = mod_reduce(im);
        return r;
    endfunction

    function automatic out_t predict_butterfly(in_t req);
        gfe_t a, b, c, w, w2, u1, u2, t, r0, r1, r2;
        out_t o;
        a = ext_load(req.a_re, req.a_im);
        b = ext_load(req.b_re, req.b_im);
        c = ext_load(req.c_re, req.c_im);
        w = ext_load(req.tw_re, req.tw_im);
        r2 = '0;
        w2 = ext_mul(w, w);
        case (req.req_type)
            REQ_FWD2: begin
                r0 = ext_add(a, b);
                r1 = ext_mul(ext_sub(a, b), w);
            end
            REQ_INV2: begin
                u1 = ext_mul(b, w);
                r0 = ext_scale(ext_add(a, u1), half_inv_q);
                r1 = ext_scale(ext_sub(a, u1), half_inv_q);
            end
            REQ_FWD3: begin
                u1 = ext_mul(b, w);
                u2 = ext_mul(c, w2);
                t = ext_scale(ext_sub(u1, u2), cube_root_q);
                r0 = ext_add(ext_add(a, u1), u2);
                r1 = ext_add(ext_sub(a, u2), t);
                r2 = ext_sub(ext_sub(a, u1), t);
            end
            default: begin
                t = ext_scale(ext_sub(b, c), cube_root_q);
                r0 = ext_scale(ext_add(ext_add(a, b), c), third_inv_q);
                r1 = ext_mul(ext_scale(ext_sub(ext_sub(a, b), t), third_inv_q), w);
                r2 = ext_mul(ext_scale(ext_add(ext_sub(a, c), t), third_inv_q), w2);
            end
        endcase
        o.out0_re = r0.re;
        o.out0_im = r0.im;
        o.out1_re = r1.re;
        o.out1_im = r1.im;
        o.out2_re = r2.re;
        o.out2_im = r2.im;
        return o;
    endfunction

    // Mostly uniform words, with the edge values 0, 1, p-1 and p mixed in.
    function automatic fe_t rand_element();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 61'd1;
            2: return P_MOD - 61'd1;
            3: return P_MOD;
            default: return fe_t'({$urandom, $urandom});
        endcase
    endfunction

    function automatic in_t rand_request();
        in_t r;
        r.req_type = 2'($urandom_range(0, 3));
        r.a_re = rand_element();
        r.a_im = rand_element();
        r.b_re = rand_element();
        r.b_im = rand_element();
        r.c_re = rand_element();
        r.c_im = rand_element();
        r.tw_re = rand_element();
        r.tw_im = rand_element();
        // Unit twiddles exercise the untwisted forms.
        if ($urandom_range(0, 7) == 0) begin
            r.tw_re = 61'd1;
            r.tw_im = '0;
        end
        return r;
    endfunction

    function automatic int draw_gap();
        return idle_gaps ? $urandom_range(0, 15) : 0;
    endfunction

    // Request driver.
    int  tx_gap = 0;
    bit  tx_next;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            tx_next = s_valid;
            if (s_valid && s_ready) begin
                expected_butterflies.push_back(predict_butterfly(s_data));
                tx_next = 1'b0;
                tx_gap = draw_gap();
            end
            if (!tx_next) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_requests.size() > 0) begin
                    s_data <= pending_requests.pop_front();
                    tx_next = 1'b1;
                end
            end
            s_valid <= tx_next;
        end
    end

    task automatic check_field(string name, fe_t want, fe_t got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10)
                $display("Mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Result monitor with its own stall pattern.
    int   rx_hold = 0;
    out_t want_out;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_butterflies.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) $display("Result arrived with none expected");
                end else begin
                    want_out = expected_butterflies.pop_front();
                    check_field("out0_re", want_out.out0_re, m_data.out0_re);
                    check_field("out0_im", want_out.out0_im, m_data.out0_im);
                    check_field("out1_re", want_out.out1_re, m_data.out1_re);
                    check_field("out1_im", want_out.out1_im, m_data.out1_im);
                    check_field("out2_re", want_out.out2_re, m_data.out2_re);
                    check_field("out2_im", want_out.out2_im, m_data.out2_im);
                end
                rx_hold = draw_gap();
            end
            // One long hold-off lets the pipeline fill and back up into the input.
            if (long_hold_req && !long_hold_done) begin
                rx_hold = 300;
                long_hold_done = 1'b1;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted traffic.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, fe_t value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_CUBE_ROOT: cube_root_q = mod_reduce(value);
            CFG_HALF_INV:  half_inv_q = mod_reduce(value);
            CFG_THIRD_INV: third_inv_q = mod_reduce(value);
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || s_valid || expected_butterflies.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) pending_requests.push_back(rand_request());
    endtask

    in_t req;
    fe_t true_cube_root;

    initial begin
        true_cube_root = mod_pow(61'd37, (P_MOD - 61'd1) / 3);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset values of the registers, cube root still zero.
        for (int m = 0; m < 4; m++) begin
            req = '0;
            req.req_type = 2'(m);
            pending_requests.push_back(req);
            req = '1;
            req.req_type = 2'(m);
            pending_requests.push_back(req);
            req.a_re = P_MOD - 61'd1; req.a_im = P_MOD - 61'd1;
            req.b_re = P_MOD - 61'd1; req.b_im = 61'd1;
            req.c_re = 61'd1;         req.c_im = P_MOD - 61'd1;
            req.tw_re = P_MOD - 61'd1; req.tw_im = P_MOD - 61'd1;
            pending_requests.push_back(req);
            req = rand_request();
            req.req_type = 2'(m);
            req.tw_re = 61'd1;
            req.tw_im = '0;
            pending_requests.push_back(req);
            req = rand_request();
            req.req_type = 2'(m);
            pending_requests.push_back(req);
        end
        queue_random(150);
        drain();

        // Proper constants, no idling on either side, one long receiver hold.
        write_reg(CFG_CUBE_ROOT, true_cube_root);
        idle_gaps = 1'b0;
        long_hold_req = 1'b1;
        queue_random(300);
        drain();

        idle_gaps = 1'b1;
        queue_random(300);
        drain();

        // The all-ones encoding of zero in every register.
        write_reg(CFG_CUBE_ROOT, P_MOD);
        write_reg(CFG_HALF_INV, P_MOD);
        write_reg(CFG_THIRD_INV, P_MOD);
        queue_random(200);
        drain();

        write_reg(CFG_CUBE_ROOT, P_MOD - 61'd1);
        write_reg(CFG_HALF_INV, '0);
        write_reg(CFG_THIRD_INV, P_MOD - 61'd1);
        // The unused index must leave everything alone.
        write_reg(CFG_UNUSED, fe_t'({$urandom, $urandom}));
        queue_random(200);
        drain();

        write_reg(CFG_CUBE_ROOT, fe_t'({$urandom, $urandom}));
        write_reg(CFG_HALF_INV, fe_t'({$urandom, $urandom}));
        write_reg(CFG_THIRD_INV, fe_t'({$urandom, $urandom}));
        idle_gaps = 1'b0;
        queue_random(200);
        drain();

        write_reg(CFG_CUBE_ROOT, true_cube_root);
        write_reg(CFG_HALF_INV, HALF_INV_RST);
        write_reg(CFG_THIRD_INV, THIRD_INV_RST);
        idle_gaps = 1'b1;
        queue_random(280);
        drain();

        if (error_count == 0 && expected_butterflies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* gf_p2_ntt_butterfly.f */
sv/gfp2_pkg.sv
sv/gfp2_delay.sv
sv/gfp2_cmul.sv
sv/gf_p2_ntt_butterfly.sv
bench/testbench.sv
